// ===== hdl/idd_pkg.sv =====
// Shared constants, widths and the month offset table for the date difference core.
package idd_pkg;

  localparam int DATE_W  = 27;
  localparam int COUNT_W = 22;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 7;

  localparam logic [YEAR_W-1:0]  MAX_YEAR    = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_CLAMP = 4'd13;
  localparam logic [COUNT_W:0]   COUNT_LIMIT = 23'd4194303;

  // Reciprocals of 25 for exact division of N-bit values: ceil(2^(N+5) / 25).
  // Dividing by 100 or 400 first drops the factor 4 or 16 with a shift.
  localparam logic [25:0] RECIP_Q    = 26'd42949673; // 25-bit dividend, shift 30
  localparam logic [19:0] RECIP_Y    = 20'd671089;   // 19-bit dividend, shift 24
  localparam logic [12:0] RECIP_C100 = 13'd5243;     // 12-bit dividend, shift 17
  localparam logic [10:0] RECIP_C400 = 11'd1311;     // 10-bit dividend, shift 15

  localparam logic [6:0]  HUNDRED    = 7'd100;
  localparam logic [8:0]  DAYS_YEAR  = 9'd365;

  // Days in a common year before the first day of the given month.
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd365;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/inclusive_date_difference_core.sv =====
// Throughput: one item per cycle; the seven stages advance together and hold
// while the result register is full and out_stall is high.
// The constant divisions by 100 and 400 are reciprocal multiplies: one in stages 1 and 3 each, three in stage 5.
// Reset (rst_n low, synchronous) clears all valid bits; the data registers are not reset.
module inclusive_date_difference_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [idd_pkg::DATE_W-1:0]   in_first_date,
  input  logic [idd_pkg::DATE_W-1:0]   in_second_date,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [idd_pkg::COUNT_W-1:0]  out_day_count
);
  import idd_pkg::*;

  logic en;

  logic [6:0] vld_r, vld_nxt;

  // Stage 1: date / 100 product.
  logic [50:0]       p1_r [2], p1_nxt [2];
  logic [DAY_W-1:0]  lo1_r [2], lo1_nxt [2];
  // Stage 2: quotient q = date / 100, day = date mod 100.
  logic [20:0]       q2_r [2], q2_nxt [2];
  logic [DAY_W-1:0]  d2_r [2], d2_nxt [2];
  // Stage 3: q / 100 product.
  logic [38:0]       p3_r [2], p3_nxt [2];
  logic [DAY_W-1:0]  qlo3_r [2], qlo3_nxt [2];
  logic [DAY_W-1:0]  d3_r [2], d3_nxt [2];
  // Stage 4: clamped year and month.
  logic [YEAR_W-1:0]  y4_r [2], y4_nxt [2];
  logic [MONTH_W-1:0] m4_r [2], m4_nxt [2];
  logic [DAY_W-1:0]   d4_r [2], d4_nxt [2];
  // Stage 5: century products and the 365 * year term.
  logic [24:0]        pa5_r [2], pa5_nxt [2];
  logic [20:0]        pb5_r [2], pb5_nxt [2];
  logic [24:0]        ph5_r [2], ph5_nxt [2];
  logic [COUNT_W-1:0] y365_5_r [2], y365_5_nxt [2];
  logic [YEAR_W-1:0]  y5_r [2], y5_nxt [2];
  logic [MONTH_W-1:0] m5_r [2], m5_nxt [2];
  logic [DAY_W-1:0]   d5_r [2], d5_nxt [2];
  // Stage 6: day number of each date.
  logic [COUNT_W-1:0] n6_r [2], n6_nxt [2];
  // Stage 7: result register.
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;

  // All stages move together unless a finished item waits at a stalled output.
  assign en       = !(vld_r[6] && out_stall);
  assign in_stall = !en;
  assign vld_nxt  = {vld_r[5:0], in_valid};

  always_comb begin
    logic [DATE_W-1:0] v;
    logic [27:0]       t100;
    logic [14:0]       y15;
    logic [21:0]       t_y;
    logic [14:0]       s99, s399, s3;
    logic [6:0]        q100, yq;
    logic [4:0]        q400;
    logic [20:0]       yq100;
    logic              cent, leap;
    for (int i = 0; i < 2; i++) begin
      v = (i == 0) ? in_first_date : in_second_date;
      p1_nxt[i]  = 51'(v[DATE_W-1:2]) * 51'(RECIP_Q);
      lo1_nxt[i] = v[DAY_W-1:0];

      q2_nxt[i] = p1_r[i][50:30];
      t100      = 28'(q2_nxt[i]) * 28'(HUNDRED);
      d2_nxt[i] = lo1_r[i] - t100[DAY_W-1:0];

      p3_nxt[i]   = 39'(q2_r[i][20:2]) * 39'(RECIP_Y);
      qlo3_nxt[i] = q2_r[i][DAY_W-1:0];
      d3_nxt[i]   = d2_r[i];

      y15        = p3_r[i][38:24];
      t_y        = 22'(y15) * 22'(HUNDRED);
      m4_nxt[i]  = (qlo3_r[i] - t_y[DAY_W-1:0] > 7'(MONTH_CLAMP)) ? MONTH_CLAMP
                 : MONTH_W'(qlo3_r[i] - t_y[DAY_W-1:0]);
      y4_nxt[i]  = (y15 > 15'(MAX_YEAR)) ? MAX_YEAR : y15[YEAR_W-1:0];
      d4_nxt[i]  = d3_r[i];

      s99          = 15'(y4_r[i]) + 15'd99;
      s399         = 15'(y4_r[i]) + 15'd399;
      pa5_nxt[i]   = 25'(s99[13:2]) * 25'(RECIP_C100);
      pb5_nxt[i]   = 21'(s399[13:4]) * 21'(RECIP_C400);
      ph5_nxt[i]   = 25'(y4_r[i][13:2]) * 25'(RECIP_C100);
      y365_5_nxt[i] = 22'(y4_r[i]) * 22'(DAYS_YEAR);
      y5_nxt[i]    = y4_r[i];
      m5_nxt[i]    = m4_r[i];
      d5_nxt[i]    = d4_r[i];

      q100  = pa5_r[i][23:17];
      q400  = pb5_r[i][19:15];
      yq    = ph5_r[i][23:17];
      yq100 = 21'(yq) * 21'(HUNDRED);
      s3    = 15'(y5_r[i]) + 15'd3;
      // Gregorian rule: every fourth year, but a century only if its quotient is.
      cent  = (21'(y5_r[i]) == yq100);
      leap  = (cent) ? (yq[1:0] == 2'b00) : (y5_r[i][1:0] == 2'b00);
      n6_nxt[i] = y365_5_r[i] + 22'(s3[14:2]) - 22'(q100) + 22'(q400)
                + 22'(days_before_month(m5_r[i]))
                + 22'(leap && (m5_r[i] >= 4'd3)) + 22'(d5_r[i]);
    end
  end

  always_comb begin
    logic [COUNT_W-1:0] diff;
    logic [COUNT_W:0]   cnt;
    diff    = (n6_r[0] > n6_r[1]) ? (n6_r[0] - n6_r[1]) : (n6_r[1] - n6_r[0]);
    cnt     = 23'(diff) + 23'd1;
    cnt_nxt = (cnt > COUNT_LIMIT) ? COUNT_LIMIT[COUNT_W-1:0] : cnt[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        p1_r[i]     <= p1_nxt[i];
        lo1_r[i]    <= lo1_nxt[i];
        q2_r[i]     <= q2_nxt[i];
        d2_r[i]     <= d2_nxt[i];
        p3_r[i]     <= p3_nxt[i];
        qlo3_r[i]   <= qlo3_nxt[i];
        d3_r[i]     <= d3_nxt[i];
        y4_r[i]     <= y4_nxt[i];
        m4_r[i]     <= m4_nxt[i];
        d4_r[i]     <= d4_nxt[i];
        pa5_r[i]    <= pa5_nxt[i];
        pb5_r[i]    <= pb5_nxt[i];
        ph5_r[i]    <= ph5_nxt[i];
        y365_5_r[i] <= y365_5_nxt[i];
        y5_r[i]     <= y5_nxt[i];
        m5_r[i]     <= m5_nxt[i];
        d5_r[i]     <= d5_nxt[i];
        n6_r[i]     <= n6_nxt[i];
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign out_valid     = vld_r[6];
  assign out_day_count = cnt_r;

endmodule

// ===== dv/inclusive_date_difference_core_tb.sv =====
// Testbench for inclusive_date_difference_core: random and directed date pairs vs a predictor.
`timescale 1ns / 1ps

class date_span_board;

  typedef struct {
    logic [idd_pkg::DATE_W-1:0]  first_date;
    logic [idd_pkg::DATE_W-1:0]  second_date;
    logic [idd_pkg::COUNT_W-1:0] day_count;
  } span_t;

  span_t expected_spans[$];
  int    fault_count;

  function new();
    fault_count = 0;
  endfunction

  static function bit year_is_leap(int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // Day index of a packed YYYYMMDD value, counted from 1 January of year 0.
  static function int unsigned epoch_day(logic [idd_pkg::DATE_W-1:0] date);
    int unsigned cum_days [0:13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304,
                                     334, 365};
    int unsigned v;
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned n;
    v  = date;
    yr = v / 10000;
    mo = (v / 100) % 100;
    dy = v % 100;
    if (yr > idd_pkg::MAX_YEAR) yr = idd_pkg::MAX_YEAR;
    // Months past December behave as the end of the year.
    if (mo > 13) mo = 13;
    n = 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400;
    n += cum_days[mo];
    if (mo >= 3 && year_is_leap(yr)) n += 1;
    return n + dy;
  endfunction

  static function logic [idd_pkg::COUNT_W-1:0] inclusive_span(
      logic [idd_pkg::DATE_W-1:0] a, logic [idd_pkg::DATE_W-1:0] b);
    int unsigned da;
    int unsigned db;
    int unsigned cnt;
    da  = epoch_day(a);
    db  = epoch_day(b);
    cnt = ((da > db) ? (da - db) : (db - da)) + 1;
    if (cnt > idd_pkg::COUNT_LIMIT) cnt = idd_pkg::COUNT_LIMIT;
    return cnt[idd_pkg::COUNT_W-1:0];
  endfunction

  function void note_pair(logic [idd_pkg::DATE_W-1:0] a, logic [idd_pkg::DATE_W-1:0] b);
    span_t s;
    s.first_date  = a;
    s.second_date = b;
    s.day_count   = inclusive_span(a, b);
    expected_spans.push_back(s);
  endfunction

  function void check_count(logic [idd_pkg::COUNT_W-1:0] got);
    span_t s;
    if (expected_spans.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("%0t: unexpected day_count %0d with no item pending", $realtime, got);
    end else begin
      s = expected_spans.pop_front();
      if (got !== s.day_count) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: day_count for %0d / %0d: expected %0d, got %0d", $realtime,
                   s.first_date, s.second_date, s.day_count, got);
      end
    end
  endfunction

  function int outstanding();
    return expected_spans.size();
  endfunction

endclass

module inclusive_date_difference_core_tb;

  import idd_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [DATE_W-1:0]  in_first_date;
  logic [DATE_W-1:0]  in_second_date;
  logic               out_valid;
  logic               out_stall;
  logic [COUNT_W-1:0] out_day_count;

  date_span_board board = new();

  bit in_calm;
  bit out_calm;
  bit draining;
  int results_seen;

  inclusive_date_difference_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_first_date (in_first_date),
    .in_second_date(in_second_date),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_day_count (out_day_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("inclusive_date_difference_core_tb: FAIL");
    $finish;
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic logic [DATE_W-1:0] pack_date(int unsigned yr, int unsigned mo,
                                                  int unsigned dy);
    int unsigned v;
    v = yr * 10000 + mo * 100 + dy;
    return v[DATE_W-1:0];
  endfunction

  function automatic int unsigned month_length(int unsigned yr, int unsigned mo);
    case (mo)
      2:            return (((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0)) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  function automatic logic [DATE_W-1:0] valid_date_in(int unsigned yr);
    int unsigned mo;
    mo = $urandom_range(1, 12);
    return pack_date(yr, mo, $urandom_range(1, month_length(yr, mo)));
  endfunction

  function automatic logic [DATE_W-1:0] malformed_date();
    return pack_date($urandom_range(0, 13420), $urandom_range(0, 99), $urandom_range(0, 99));
  endfunction

  function automatic int unsigned leap_edge_year();
    case ($urandom_range(0, 3))
      0:       return 400 * $urandom_range(0, 24);
      1:       return 100 * $urandom_range(0, 99);
      2:       return 4 * $urandom_range(0, 2499);
      default: return $urandom_range(0, 9999);
    endcase
  endfunction

  // Entered and left at a falling edge; the item is noted at its accepting edge.
  task automatic send_pair(input logic [DATE_W-1:0] a, input logic [DATE_W-1:0] b);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_first_date  <= a;
    in_second_date <= b;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_pair(a, b);
    @(negedge clk);
  endtask

  task automatic send_random_pair();
    int kind;
    int unsigned yr;
    logic [DATE_W-1:0] a;
    logic [DATE_W-1:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      a = valid_date_in($urandom_range(0, 9999));
      b = valid_date_in($urandom_range(0, 9999));
    end else if (kind < 55) begin
      yr = $urandom_range(0, 9999);
      a  = valid_date_in(yr);
      b  = valid_date_in(yr);
    end else if (kind < 62) begin
      a = valid_date_in($urandom_range(0, 9999));
      b = a;
    end else if (kind < 72) begin
      yr = leap_edge_year();
      a  = pack_date(yr, 2, $urandom_range(28, 29));
      b  = pack_date(yr, 3, 1);
    end else if (kind < 86) begin
      a = malformed_date();
      b = ($urandom_range(0, 1) == 1) ? malformed_date()
                                      : valid_date_in($urandom_range(0, 9999));
    end else begin
      a = DATE_W'($urandom);
      b = ($urandom_range(0, 1) == 1) ? DATE_W'($urandom)
                                      : valid_date_in($urandom_range(0, 9999));
    end
    if ($urandom_range(0, 1) == 1) send_pair(b, a);
    else send_pair(a, b);
  endtask

  // Result side: checks at the rising edge, chooses the next stall at the falling edge.
  initial begin
    int stall_run;
    int hold_left;
    int cycle;
    bit held_early;
    bit held_late;
    stall_run  = 0;
    hold_left  = 0;
    cycle      = 0;
    held_early = 0;
    held_late  = 0;
    out_stall  = 1'b0;
    out_calm   = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        board.check_count(out_day_count);
        results_seen++;
      end
      @(negedge clk);
      cycle++;
      if (cycle % 64 == 0) out_calm = ($urandom_range(0, 3) == 0);
      // Two long holds let the pipeline fill and push back on the sender.
      if (!held_early && results_seen >= 150) begin
        held_early = 1;
        hold_left  = 100;
      end
      if (!held_late && results_seen >= 900) begin
        held_late = 1;
        hold_left = 120;
      end
      if (draining) begin
        out_stall <= 1'b0;
      end else if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else begin
        out_stall <= 1'b0;
        stall_run = pick_gap(out_calm);
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_first_date  = '0;
    in_second_date = '0;
    in_calm        = 1'b0;
    draining       = 1'b0;
    results_seen   = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pair(pack_date(0, 1, 1), pack_date(0, 1, 1));
    send_pair(pack_date(0, 1, 1), pack_date(9999, 12, 31));
    send_pair(pack_date(9999, 12, 31), pack_date(0, 1, 1));
    send_pair('0, '0);
    send_pair('1, '0);
    send_pair('1, '1);
    send_pair(pack_date(2000, 2, 28), pack_date(2000, 3, 1));
    send_pair(pack_date(1900, 2, 28), pack_date(1900, 3, 1));
    send_pair(pack_date(2024, 3, 1), pack_date(2024, 2, 29));
    send_pair(pack_date(0, 2, 28), pack_date(0, 3, 1));
    send_pair(pack_date(400, 2, 29), pack_date(400, 3, 1));
    send_pair(pack_date(100, 2, 28), pack_date(100, 3, 1));
    send_pair(pack_date(2023, 0, 0), pack_date(2023, 1, 1));
    send_pair(pack_date(2023, 13, 0), pack_date(2023, 12, 31));
    send_pair(pack_date(2023, 99, 15), pack_date(2024, 1, 1));
    send_pair(pack_date(2023, 2, 0), pack_date(2023, 1, 31));
    send_pair(pack_date(2023, 2, 99), pack_date(2023, 3, 1));
    send_pair(pack_date(9999, 12, 31), pack_date(9999, 12, 30));
    send_pair(pack_date(10000, 1, 1), pack_date(9999, 12, 31));
    send_pair(pack_date(13421, 77, 27), pack_date(0, 0, 0));
    send_pair(pack_date(1999, 12, 31), pack_date(2000, 1, 1));
    send_pair(pack_date(2023, 1, 1), pack_date(2023, 12, 31));

    for (int i = 0; i < 1650; i++) begin
      if (i % 50 == 0) in_calm = ($urandom_range(0, 3) == 0);
      send_random_pair();
    end
    in_valid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    draining = 1'b1;
    repeat (20) @(posedge clk);
    if (board.fault_count == 0 && board.outstanding() == 0) begin
      $display("inclusive_date_difference_core_tb: PASS");
    end else begin
      $display("inclusive_date_difference_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== inclusive_date_difference_core.f =====
hdl/idd_pkg.sv
hdl/inclusive_date_difference_core.sv
dv/inclusive_date_difference_core_tb.sv
